### sv/mtq_pkg.sv
// Shared types and constants of the MIDI transmit queue.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package mtq_pkg;

    typedef enum logic [1:0] {
        FUNC_ENQ   = 2'd0,
        FUNC_SYSEX = 2'd1,
        FUNC_DEQ   = 2'd2,
        FUNC_TICK  = 2'd3
    } t_func;

    localparam logic [2:0] TYPE_NOTE_ON  = 3'd0;
    localparam logic [2:0] TYPE_NOTE_OFF = 3'd1;
    localparam logic [2:0] TYPE_CC       = 3'd2;
    localparam logic [2:0] TYPE_BEND     = 3'd3;
    localparam logic [2:0] TYPE_RT       = 3'd4;
    localparam logic [2:0] TYPE_SYSEX    = 3'd5;

    localparam logic [15:0] INTERVAL_RESET = 16'd960;
    localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  mtype;
        logic [3:0]  chan;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [13:0] bend;
        logic [7:0]  rt;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
        logic cmp;
        logic upd;
    } t_cell_ctl;

    typedef struct packed {
        logic tick;
        logic clear;
    } t_pace_ctl;

endpackage
`default_nettype wire

### sv/midi_tx_queue_coalesce_pace.sv
// Top level of the MIDI transmit queue with CC coalescing and send pacing.
// Uses mtq_pkg, mtq_cell and mtq_pace.
//
// Usage:
//   A request (i_func and message fields) is taken at a clock edge where
//   start is high and busy is low. Requests: enqueue message, enqueue SysEx
//   marker, dequeue, one microsecond tick.
//   Every request gives exactly one result, shown on the o_ result ports for
//   one cycle with o_done high. The receiver cannot stall; a result that is
//   not taken in that cycle is gone.
//   After the accepting edge a request passes through the compare state and
//   then the execute state, with busy high in both, and o_done is registered
//   from the execute state; no new request is taken before that state is left.
//   The compare state is the compare pass of the cell row (every cell checks its
//   entry against the new Control Change, registered), the execute state the update pass.
//   The queue is a row of QUEUE_DEPTH cells with the head in cell 0; a pop
//   shifts every cell one place toward the head in the same cycle.
//   i_cfg_we/i_cfg_wdata write the minimum send interval (microseconds);
//   write only while no request is in flight.
//   Reset clears the fill count, the SysEx slot count, the elapsed counter
//   and the sent flag, and sets the interval to 960. Cell contents stay.
`default_nettype none
module midi_tx_queue_coalesce_pace #(
    parameter int QUEUE_DEPTH = 16,
    parameter int SYSEX_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_func,
    input  wire  [2:0]  i_msg_type,
    input  wire  [3:0]  i_channel,
    input  wire  [6:0]  i_data_one,
    input  wire  [6:0]  i_data_two,
    input  wire  [13:0] i_bend_value,
    input  wire  [7:0]  i_realtime_code,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_wdata,
    output logic        o_done,
    output logic        o_accepted,
    output logic        o_sent_valid,
    output logic        o_pace_hold,
    output logic [2:0]  o_out_type,
    output logic [3:0]  o_out_channel,
    output logic [6:0]  o_out_data_one,
    output logic [6:0]  o_out_data_two,
    output logic [13:0] o_out_bend,
    output logic [7:0]  o_out_realtime,
    output logic [4:0]  o_queue_level
);
    import mtq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(SYSEX_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state          r_state, n_state;
    t_func           r_func;
    t_entry          r_new, n_new;
    logic            r_type_ok;
    logic [CW-1:0]   r_count, n_count;
    logic [SW-1:0]   r_sx, n_sx;

    logic            r_done, r_accepted, r_sent, r_limited;
    t_entry          r_out;
    logic [4:0]      r_level;
    logic            n_accepted, n_sent, n_limited;
    t_entry          n_out;

    t_entry                  w_cell [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]  w_hit;
    t_cell_ctl               w_ctl  [QUEUE_DEPTH];
    logic                    w_shift, w_load, w_upd;
    t_pace_ctl               w_pace;
    logic                    w_may_send;
    logic                    w_accept;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    // new entry, unused fields zero
    always_comb begin
        n_new = '0;
        if (t_func'(i_func) == FUNC_SYSEX) begin
            n_new.mtype = TYPE_SYSEX;
        end else begin
            n_new.mtype = i_msg_type;
            if (i_msg_type == TYPE_RT) begin
                n_new.rt = i_realtime_code;
            end else begin
                n_new.chan = i_channel;
                if (i_msg_type == TYPE_BEND) begin
                    n_new.bend = i_bend_value;
                end else begin
                    n_new.d1 = i_data_one;
                    n_new.d2 = i_data_two;
                end
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_entry w_next;
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_next = w_cell[g];
            end else begin : g_mid
                assign w_next = w_cell[g+1];
            end
            assign w_ctl[g] = '{shift: w_shift,
                                load:  w_load && (r_count == CW'(g)),
                                cmp:   (r_state == S_CMP),
                                upd:   w_upd};
            mtq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl[g]),
                .i_occupied (CW'(g) < r_count),
                .i_next     (w_next),
                .i_new      (r_new),
                .o_entry    (w_cell[g]),
                .o_hit      (w_hit[g])
            );
        end
    endgenerate

    mtq_pace u_pace (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctl       (w_pace),
        .o_may_send  (w_may_send)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_sx       = r_sx;
        n_accepted = 1'b0;
        n_sent     = 1'b0;
        n_limited  = 1'b0;
        n_out      = '0;
        w_shift    = 1'b0;
        w_load     = 1'b0;
        w_upd      = 1'b0;
        w_pace     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_func)
                    FUNC_ENQ: begin
                        if (r_type_ok) begin
                            if ((r_new.mtype == TYPE_CC) && (|w_hit)) begin
                                w_upd      = 1'b1;
                                n_accepted = 1'b1;
                            end else if (r_count < CW'(QUEUE_DEPTH)) begin
                                w_load     = 1'b1;
                                n_count    = r_count + CW'(1);
                                n_accepted = 1'b1;
                            end
                        end
                    end
                    FUNC_SYSEX: begin
                        if ((r_count < CW'(QUEUE_DEPTH)) && (r_sx < SW'(SYSEX_DEPTH))) begin
                            w_load     = 1'b1;
                            n_count    = r_count + CW'(1);
                            n_sx       = r_sx + SW'(1);
                            n_accepted = 1'b1;
                        end
                    end
                    FUNC_DEQ: begin
                        if (r_count != '0) begin
                            if ((w_cell[0].mtype == TYPE_RT) || w_may_send) begin
                                w_shift = 1'b1;
                                n_count = r_count - CW'(1);
                                n_sent  = 1'b1;
                                n_out   = w_cell[0];
                                if ((w_cell[0].mtype == TYPE_SYSEX) && (r_sx != '0)) begin
                                    n_sx = r_sx - SW'(1);
                                end
                                if (w_cell[0].mtype != TYPE_RT) begin
                                    w_pace.clear = 1'b1;
                                end
                            end else begin
                                n_limited = 1'b1;
                            end
                        end
                    end
                    FUNC_TICK: begin
                        w_pace.tick = 1'b1;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_sx    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sx    <= n_sx;
            r_done  <= (r_state == S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func    <= t_func'(i_func);
            r_new     <= n_new;
            r_type_ok <= (i_msg_type <= TYPE_RT);
        end
        if (r_state == S_EXEC) begin
            r_accepted <= n_accepted;
            r_sent     <= n_sent;
            r_limited  <= n_limited;
            r_out      <= n_out;
            r_level    <= 5'(n_count);
        end
    end

    assign o_done         = r_done;
    assign o_accepted     = r_accepted;
    assign o_sent_valid   = r_sent;
    assign o_pace_hold    = r_limited;
    assign o_out_type     = r_out.mtype;
    assign o_out_channel  = r_out.chan;
    assign o_out_data_one = r_out.d1;
    assign o_out_data_two = r_out.d2;
    assign o_out_bend     = r_out.bend;
    assign o_out_realtime = r_out.rt;
    assign o_queue_level  = r_level;

endmodule
`default_nettype wire

### sv/mtq_cell.sv
// One queue cell: holds one entry, shifts toward the head on pop,
// and flags a matching Control Change. Uses mtq_pkg.
`default_nettype none
module mtq_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mtq_pkg::t_cell_ctl   i_ctl,
    input  wire                  i_occupied,
    input  mtq_pkg::t_entry      i_next,
    input  mtq_pkg::t_entry      i_new,
    output mtq_pkg::t_entry      o_entry,
    output logic                 o_hit
);
    import mtq_pkg::*;

    t_entry r_entry;
    logic   r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_next;
        end else if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.upd && r_hit) begin
            r_entry.d2 <= i_new.d2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_hit <= i_occupied && (r_entry.mtype == TYPE_CC)
                     && (r_entry.chan == i_new.chan) && (r_entry.d1 == i_new.d1);
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule
`default_nettype wire

### sv/mtq_pace.sv
// Send pacing: elapsed microsecond counter, sent-once flag and the
// minimum interval register. Uses mtq_pkg.
`default_nettype none
module mtq_pace (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [15:0]           i_cfg_wdata,
    input  mtq_pkg::t_pace_ctl   i_ctl,
    output logic                 o_may_send
);
    import mtq_pkg::*;

    logic [15:0] r_elapsed;
    logic [15:0] r_interval;
    logic        r_ever;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed  <= '0;
            r_interval <= INTERVAL_RESET;
            r_ever     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            if (i_ctl.clear) begin
                r_elapsed <= '0;
                r_ever    <= 1'b1;
            end else if (i_ctl.tick && (r_elapsed != ELAPSED_MAX)) begin
                r_elapsed <= r_elapsed + 16'd1;
            end
        end
    end

    assign o_may_send = !r_ever || (r_elapsed >= r_interval);

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for midi_tx_queue_coalesce_pace: directed and random requests.
// Keeps a shadow queue with pacing state and checks every result field.
// Depends on mtq_pkg and the midi_tx_queue_coalesce_pace RTL.
module testbench;
    import mtq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int SYSEX_DEPTH = 4;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        t_func       func;
        logic [2:0]  mtype;
        logic [3:0]  chan;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [13:0] bend;
        logic [7:0]  rt;
    } t_request;

    typedef struct packed {
        logic        accepted;
        logic        sent;
        logic        limited;
        logic [2:0]  otype;
        logic [3:0]  chan;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [13:0] bend;
        logic [7:0]  rt;
        logic [4:0]  level;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  req_func = '0;
    logic [2:0]  req_type = '0;
    logic [3:0]  req_chan = '0;
    logic [6:0]  req_d1 = '0;
    logic [6:0]  req_d2 = '0;
    logic [13:0] req_bend = '0;
    logic [7:0]  req_rt = '0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        o_done;
    logic        o_accepted;
    logic        o_sent_valid;
    logic        o_pace_hold;
    logic [2:0]  o_out_type;
    logic [3:0]  o_out_channel;
    logic [6:0]  o_out_data_one;
    logic [6:0]  o_out_data_two;
    logic [13:0] o_out_bend;
    logic [7:0]  o_out_realtime;
    logic [4:0]  o_queue_level;

    t_outcome    pending_outcomes[$];
    t_entry      shadow_fifo[$];
    int          sysex_held = 0;
    logic [15:0] elapsed_us = '0;
    bit          sent_once = 1'b0;
    logic [15:0] interval_us = INTERVAL_RESET;
    int          send_idle_pct = 36;
    int          quiet_cycles = 0;
    bit          failed = 1'b0;

    midi_tx_queue_coalesce_pace #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .SYSEX_DEPTH(SYSEX_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (req_func),
        .i_msg_type     (req_type),
        .i_channel      (req_chan),
        .i_data_one     (req_d1),
        .i_data_two     (req_d2),
        .i_bend_value   (req_bend),
        .i_realtime_code(req_rt),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .o_done         (o_done),
        .o_accepted     (o_accepted),
        .o_sent_valid   (o_sent_valid),
        .o_pace_hold    (o_pace_hold),
        .o_out_type     (o_out_type),
        .o_out_channel  (o_out_channel),
        .o_out_data_one (o_out_data_one),
        .o_out_data_two (o_out_data_two),
        .o_out_bend     (o_out_bend),
        .o_out_realtime (o_out_realtime),
        .o_queue_level  (o_queue_level)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_outcome predict_outcome(input t_request rq);
        t_outcome res;
        t_entry   ent;
        t_entry   cur;
        bit       hit;
        res = '0;
        ent = '0;
        hit = 1'b0;
        case (rq.func)
            FUNC_ENQ: begin
                if (rq.mtype <= TYPE_RT) begin
                    ent.mtype = rq.mtype;
                    if (rq.mtype == TYPE_RT) begin
                        ent.rt = rq.rt;
                    end else begin
                        ent.chan = rq.chan;
                        if (rq.mtype == TYPE_BEND) begin
                            ent.bend = rq.bend;
                        end else begin
                            ent.d1 = rq.d1;
                            ent.d2 = rq.d2;
                        end
                    end
                    if (rq.mtype == TYPE_CC) begin
                        for (int i = 0; i < shadow_fifo.size() && !hit; i++) begin
                            cur = shadow_fifo[i];
                            if (cur.mtype == TYPE_CC && cur.chan == ent.chan
                                && cur.d1 == ent.d1) begin
                                cur.d2 = ent.d2;
                                shadow_fifo[i] = cur;
                                hit = 1'b1;
                            end
                        end
                    end
                    if (!hit && shadow_fifo.size() < QUEUE_DEPTH) begin
                        shadow_fifo.insert(shadow_fifo.size(), ent);
                        hit = 1'b1;
                    end
                    res.accepted = hit;
                end
            end
            FUNC_SYSEX: begin
                if (shadow_fifo.size() < QUEUE_DEPTH && sysex_held < SYSEX_DEPTH) begin
                    ent.mtype = TYPE_SYSEX;
                    shadow_fifo.insert(shadow_fifo.size(), ent);
                    sysex_held++;
                    res.accepted = 1'b1;
                end
            end
            FUNC_DEQ: begin
                if (shadow_fifo.size() > 0) begin
                    cur = shadow_fifo[0];
                    if (cur.mtype == TYPE_RT || !sent_once || elapsed_us >= interval_us) begin
                        shadow_fifo.delete(0);
                        if (cur.mtype == TYPE_SYSEX && sysex_held > 0) begin
                            sysex_held--;
                        end
                        if (cur.mtype != TYPE_RT) begin
                            elapsed_us = '0;
                            sent_once = 1'b1;
                        end
                        res.sent = 1'b1;
                        res.otype = cur.mtype;
                        res.chan = cur.chan;
                        res.d1 = cur.d1;
                        res.d2 = cur.d2;
                        res.bend = cur.bend;
                        res.rt = cur.rt;
                    end else begin
                        res.limited = 1'b1;
                    end
                end
            end
            default: begin
                if (elapsed_us != ELAPSED_MAX) begin
                    elapsed_us = elapsed_us + 16'd1;
                end
            end
        endcase
        res.level = 5'(shadow_fifo.size());
        return res;
    endfunction

    function automatic t_request make_request(input t_func f, input logic [2:0] mt,
                                              input logic [3:0] ch, input logic [6:0] d1,
                                              input logic [6:0] d2, input logic [13:0] bend,
                                              input logic [7:0] rt);
        t_request rq;
        rq.func = f;
        rq.mtype = mt;
        rq.chan = ch;
        rq.d1 = d1;
        rq.d2 = d2;
        rq.bend = bend;
        rq.rt = rt;
        return rq;
    endfunction

    function automatic t_request random_request();
        t_request rq;
        int       pick;
        rq = make_request(FUNC_TICK, 3'($urandom_range(4)), 4'($urandom_range(15)),
                          7'($urandom_range(127)), 7'($urandom_range(127)),
                          14'($urandom_range(16383)), 8'($urandom_range(255)));
        pick = $urandom_range(99);
        if (pick < 42) begin
            rq.func = FUNC_ENQ;
        end else if (pick < 49) begin
            rq.func = FUNC_SYSEX;
        end else if (pick < 78) begin
            rq.func = FUNC_DEQ;
        end
        pick = $urandom_range(99);
        if (pick < 6) begin
            rq.mtype = 3'($urandom_range(7, 5));
        end else if (pick < 40) begin
            rq.mtype = TYPE_CC;
        end
        // narrow keys so CC coalescing hits often
        if ($urandom_range(1)) begin
            rq.chan = 4'($urandom_range(1));
            rq.d1 = 7'($urandom_range(2));
        end
        return rq;
    endfunction

    // call at a falling edge
    task automatic send_request(input t_request rq);
        t_outcome predicted;
        req_func <= rq.func;
        req_type <= rq.mtype;
        req_chan <= rq.chan;
        req_d1 <= rq.d1;
        req_d2 <= rq.d2;
        req_bend <= rq.bend;
        req_rt <= rq.rt;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        predicted = predict_outcome(rq);
        pending_outcomes.insert(pending_outcomes.size(), predicted);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_interval(input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        interval_us = value;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome exp;
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result with no request pending", $time);
                failed = 1'b1;
            end else begin
                exp = pending_outcomes[0];
                pending_outcomes.delete(0);
                check_field("accepted", 16'(exp.accepted), 16'(o_accepted));
                check_field("sent_valid", 16'(exp.sent), 16'(o_sent_valid));
                check_field("pace_hold", 16'(exp.limited), 16'(o_pace_hold));
                check_field("out_type", 16'(exp.otype), 16'(o_out_type));
                check_field("out_channel", 16'(exp.chan), 16'(o_out_channel));
                check_field("out_data_one", 16'(exp.d1), 16'(o_out_data_one));
                check_field("out_data_two", 16'(exp.d2), 16'(o_out_data_two));
                check_field("out_bend", 16'(exp.bend), 16'(o_out_bend));
                check_field("out_realtime", 16'(exp.rt), 16'(o_out_realtime));
                check_field("queue_level", 16'(exp.level), 16'(o_queue_level));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // reset interval: first send is free, the next one is paced
    task automatic test_empty_and_first_send();
        send_request(make_request(FUNC_DEQ, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
        send_request(make_request(FUNC_ENQ, TYPE_NOTE_ON, 4'd15, 7'd127, 7'd127, 14'h3FFF, 8'hFF));
        for (int t = 5; t <= 7; t++) begin
            send_request(make_request(FUNC_ENQ, 3'(t), 4'd2, 7'd3, 7'd4, 14'd5, 8'd6));
        end
        send_request(make_request(FUNC_DEQ, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
        send_request(make_request(FUNC_ENQ, TYPE_NOTE_OFF, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
        send_request(make_request(FUNC_DEQ, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
        send_request(make_request(FUNC_ENQ, TYPE_RT, 4'd15, 7'd127, 7'd127, 14'h3FFF, 8'hFF));
        send_request(make_request(FUNC_DEQ, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
    endtask

    // held one tick short of the interval, sent once it is reached
    task automatic test_tick_pacing();
        wait_drained();
        write_interval(16'd40);
        repeat (39) begin
            send_request(make_request(FUNC_TICK, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
        end
        send_request(make_request(FUNC_DEQ, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
        send_request(make_request(FUNC_TICK, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
        repeat (2) begin
            send_request(make_request(FUNC_DEQ, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
        end
        send_request(make_request(FUNC_ENQ, TYPE_BEND, 4'd9, 7'd1, 7'd1, 14'h3FFF, 8'd1));
        send_request(make_request(FUNC_DEQ, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
    endtask

    task automatic test_coalesce_when_full();
        t_request rq;
        wait_drained();
        write_interval(16'd0);
        send_request(make_request(FUNC_ENQ, TYPE_CC, 4'd3, 7'd7, 7'd1, 14'd0, 8'd0));
        send_request(make_request(FUNC_ENQ, TYPE_CC, 4'd3, 7'd7, 7'd99, 14'd0, 8'd0));
        repeat (5) begin
            send_request(make_request(FUNC_SYSEX, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
        end
        while (shadow_fifo.size() < QUEUE_DEPTH) begin
            rq = random_request();
            rq.func = FUNC_ENQ;
            rq.mtype = $urandom_range(1) ? TYPE_NOTE_ON : TYPE_BEND;
            send_request(rq);
        end
        send_request(make_request(FUNC_ENQ, TYPE_NOTE_OFF, 4'd1, 7'd1, 7'd1, 14'd0, 8'd0));
        send_request(make_request(FUNC_ENQ, TYPE_CC, 4'd3, 7'd7, 7'd42, 14'd0, 8'd0));
        send_request(make_request(FUNC_SYSEX, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
        while (shadow_fifo.size() > 0) begin
            send_request(make_request(FUNC_DEQ, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
        end
        send_request(make_request(FUNC_DEQ, TYPE_NOTE_ON, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0));
    endtask

    task automatic test_random_traffic(input int idle_pct, input logic [15:0] interval,
                                       input int count);
        wait_drained();
        write_interval(interval);
        send_idle_pct = idle_pct;
        repeat (count) send_request(random_request());
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_and_first_send();
        test_tick_pacing();
        test_coalesce_when_full();
        test_random_traffic(36, 16'd2, 335);
        test_random_traffic(65, 16'd6, 335);
        test_random_traffic(0, 16'd1, 335);
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (!failed) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

### filelist.f
sv/mtq_pkg.sv
sv/mtq_cell.sv
sv/mtq_pace.sv
sv/midi_tx_queue_coalesce_pace.sv
dv/testbench.sv
